[hdl/lcdseq_pkg.sv]
// types, microprogram and lookup tables for the character lcd write sequencer
`timescale 1ns / 1ps
`default_nettype none

package lcdseq_pkg;

    // request kinds
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_CURSOR = 2'd3
    } lcd_op_t;

    // where the event's port byte comes from
    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_OPND  = 2'd1,
        SRC_KEEP  = 2'd2
    } byte_src_t;

    // which part of the byte goes on the port
    typedef enum logic [1:0] {
        PART_FULL = 2'd0,
        PART_HI   = 2'd1,
        PART_LO   = 2'd2
    } byte_part_t;

    // hold time selection; gap is 0 us for data and 100 us for commands
    typedef enum logic [2:0] {
        HOLD_0    = 3'd0,
        HOLD_1    = 3'd1,
        HOLD_100  = 3'd2,
        HOLD_2000 = 3'd3,
        HOLD_GAP  = 3'd4
    } hold_sel_t;

    localparam int HoldW    = 11;
    localparam int RomDepth = 50;
    localparam int UpcW     = $clog2(RomDepth);

    localparam logic [HoldW-1:0] HoldPulse = HoldW'(1);
    localparam logic [HoldW-1:0] HoldShort = HoldW'(100);
    localparam logic [HoldW-1:0] HoldLong  = HoldW'(2000);

    // program entry points
    localparam logic [UpcW-1:0] EntryInit4   = UpcW'(0);
    localparam logic [UpcW-1:0] EntryInit8   = UpcW'(26);
    localparam logic [UpcW-1:0] EntryByte4   = UpcW'(36);
    localparam logic [UpcW-1:0] EntryByte8   = UpcW'(40);
    localparam logic [UpcW-1:0] EntryCursor4 = UpcW'(42);
    localparam logic [UpcW-1:0] EntryCursor8 = UpcW'(47);

    typedef struct packed {
        byte_src_t  src;
        byte_part_t part;
        logic [7:0] lit;
        logic       rs_from_op;
        logic       en;
        hold_sel_t  hold;
        logic       last;
    } ctrl_word_t;

    function automatic ctrl_word_t mk(input byte_src_t src, input byte_part_t part,
                                      input logic [7:0] lit, input logic rs_from_op,
                                      input logic en, input hold_sel_t hold,
                                      input logic last);
        ctrl_word_t w;
        w.src        = src;
        w.part       = part;
        w.lit        = lit;
        w.rs_from_op = rs_from_op;
        w.en         = en;
        w.hold       = hold;
        w.last       = last;
        return w;
    endfunction

    // the microprogram, one pin event per word
    function automatic ctrl_word_t rom_word(input logic [UpcW-1:0] addr);
        ctrl_word_t w;
        case (addr)
            // init, 4-bit bus
            6'd0:  w = mk(SRC_CONST, PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_0,    1'b0);
            6'd1:  w = mk(SRC_CONST, PART_HI,   8'h33, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd2:  w = mk(SRC_CONST, PART_HI,   8'h33, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd3:  w = mk(SRC_CONST, PART_LO,   8'h33, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd4:  w = mk(SRC_CONST, PART_LO,   8'h33, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd5:  w = mk(SRC_CONST, PART_HI,   8'h32, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd6:  w = mk(SRC_CONST, PART_HI,   8'h32, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd7:  w = mk(SRC_CONST, PART_LO,   8'h32, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd8:  w = mk(SRC_CONST, PART_LO,   8'h32, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd9:  w = mk(SRC_CONST, PART_HI,   8'h28, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd10: w = mk(SRC_CONST, PART_HI,   8'h28, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd11: w = mk(SRC_CONST, PART_LO,   8'h28, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd12: w = mk(SRC_CONST, PART_LO,   8'h28, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd13: w = mk(SRC_CONST, PART_HI,   8'h0E, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd14: w = mk(SRC_CONST, PART_HI,   8'h0E, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd15: w = mk(SRC_CONST, PART_LO,   8'h0E, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd16: w = mk(SRC_CONST, PART_LO,   8'h0E, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd17: w = mk(SRC_CONST, PART_HI,   8'h01, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd18: w = mk(SRC_CONST, PART_HI,   8'h01, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd19: w = mk(SRC_CONST, PART_LO,   8'h01, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd20: w = mk(SRC_CONST, PART_LO,   8'h01, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd21: w = mk(SRC_KEEP,  PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_2000, 1'b0);
            6'd22: w = mk(SRC_CONST, PART_HI,   8'h06, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd23: w = mk(SRC_CONST, PART_HI,   8'h06, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd24: w = mk(SRC_CONST, PART_LO,   8'h06, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd25: w = mk(SRC_CONST, PART_LO,   8'h06, 1'b0, 1'b0, HOLD_100,  1'b1);
            // init, 8-bit bus
            6'd26: w = mk(SRC_CONST, PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_2000, 1'b0);
            6'd27: w = mk(SRC_CONST, PART_FULL, 8'h38, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd28: w = mk(SRC_CONST, PART_FULL, 8'h38, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd29: w = mk(SRC_CONST, PART_FULL, 8'h0E, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd30: w = mk(SRC_CONST, PART_FULL, 8'h0E, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd31: w = mk(SRC_CONST, PART_FULL, 8'h01, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd32: w = mk(SRC_CONST, PART_FULL, 8'h01, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd33: w = mk(SRC_KEEP,  PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_2000, 1'b0);
            6'd34: w = mk(SRC_CONST, PART_FULL, 8'h06, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd35: w = mk(SRC_CONST, PART_FULL, 8'h06, 1'b0, 1'b0, HOLD_100,  1'b1);
            // command or data byte, 4-bit bus
            6'd36: w = mk(SRC_OPND,  PART_HI,   8'h00, 1'b1, 1'b1, HOLD_1,    1'b0);
            6'd37: w = mk(SRC_OPND,  PART_HI,   8'h00, 1'b1, 1'b0, HOLD_GAP,  1'b0);
            6'd38: w = mk(SRC_OPND,  PART_LO,   8'h00, 1'b1, 1'b1, HOLD_1,    1'b0);
            6'd39: w = mk(SRC_OPND,  PART_LO,   8'h00, 1'b1, 1'b0, HOLD_100,  1'b1);
            // command or data byte, 8-bit bus
            6'd40: w = mk(SRC_OPND,  PART_FULL, 8'h00, 1'b1, 1'b1, HOLD_1,    1'b0);
            6'd41: w = mk(SRC_OPND,  PART_FULL, 8'h00, 1'b1, 1'b0, HOLD_100,  1'b1);
            // set cursor, 4-bit bus
            6'd42: w = mk(SRC_OPND,  PART_HI,   8'h00, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd43: w = mk(SRC_OPND,  PART_HI,   8'h00, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd44: w = mk(SRC_OPND,  PART_LO,   8'h00, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd45: w = mk(SRC_OPND,  PART_LO,   8'h00, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd46: w = mk(SRC_KEEP,  PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_100,  1'b1);
            // set cursor, 8-bit bus
            6'd47: w = mk(SRC_OPND,  PART_FULL, 8'h00, 1'b0, 1'b1, HOLD_1,    1'b0);
            6'd48: w = mk(SRC_OPND,  PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_100,  1'b0);
            6'd49: w = mk(SRC_KEEP,  PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_100,  1'b1);
            default: w = mk(SRC_KEEP, PART_FULL, 8'h00, 1'b0, 1'b0, HOLD_0,   1'b1);
        endcase
        return w;
    endfunction

    // dispatch: first word of the program for a request kind and bus width
    function automatic logic [UpcW-1:0] entry_addr(input lcd_op_t op, input logic four_bit);
        logic [UpcW-1:0] a;
        case (op)
            OP_INIT:   a = four_bit ? EntryInit4   : EntryInit8;
            OP_CMD:    a = four_bit ? EntryByte4   : EntryByte8;
            OP_DATA:   a = four_bit ? EntryByte4   : EntryByte8;
            OP_CURSOR: a = four_bit ? EntryCursor4 : EntryCursor8;
            default:   a = EntryInit4;
        endcase
        return a;
    endfunction

    // ddram base address of each display row
    function automatic logic [7:0] row_base(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h94;
            2'd3:    b = 8'hD4;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hdl/char_lcd_bus_write_sequencer.sv]
// top level: microcoded sequencer that turns lcd requests into timed pin events
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one request for an HD44780-style character LCD:
// power-up init, command byte, data byte or set cursor. The block answers with
// a run of pin events on the output stream, one transaction per event, each
// giving the data port byte, RS, RW (always write), EN and the number of
// microseconds the levels must be held; tlast marks the final event of a run.
// The bus width comes from cfg_wdata written with cfg_we (1 = 4-bit nibble
// transfers, 0 = 8-bit) and resets to 4-bit; write it only while the block is
// idle. Row and column are clamped to 1..4 and 1..20 before the cursor address
// is formed. Runs are fixed by a 50-word microprogram held in a constant
// table: a request dispatches to its program entry and a step counter walks it,
// one event per clock while the output side takes them. A run is 26 events for
// 4-bit init, 10 for 8-bit init, 4 or 2 for a byte, and 5 or 3 for set cursor,
// so a request occupies the block for its dispatch plus one step per event,
// plus any output stalls.
// The next request is taken in the cycle after the last event has been staged,
// even while that event still waits in the output register.
module char_lcd_bus_write_sequencer
    import lcdseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration: bus_is_4bit
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,

    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // byte_value[7:0], column[12:8], row[15:13]
    input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]

    // pin event stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // port_byte[7:0], read_write[8],
                                             // enable_pin[9], hold_us[20:10], zero fill
    output logic             m_axis_tuser,   // reg_select
    output logic             m_axis_tlast    // last_event
);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [UpcW-1:0]  upc_reg, upc_next;
    logic             bus_is_4bit_reg;

    // operand latched at request time: the byte, or the cursor address
    logic [7:0]       operand_reg;
    logic             rs_op_reg;

    // output register
    logic             out_valid_reg;
    logic [7:0]       port_reg;
    logic             rs_reg;
    logic             en_reg;
    logic [HoldW-1:0] hold_reg;
    logic             last_reg;

    // request fields
    lcd_op_t    req_op;
    logic [7:0] req_byte;
    logic [4:0] req_col;
    logic [2:0] req_row;

    logic [4:0] col_clamped;
    logic [1:0] row_idx;
    logic [7:0] cursor_addr;

    logic       accept;
    logic       step;
    ctrl_word_t cw;
    logic [7:0] src_byte;
    logic [7:0] ev_port;
    logic [HoldW-1:0] ev_hold;

    assign req_op   = lcd_op_t'(s_axis_tuser);
    assign req_byte = s_axis_tdata[7:0];
    assign req_col  = s_axis_tdata[12:8];
    assign req_row  = s_axis_tdata[15:13];

    // clamp row to 1..4 and column to 1..20, then base + column - 1
    always_comb
    begin
        if (req_row == 3'd0)
        begin
            row_idx = 2'd0;
        end
        else if (req_row > 3'd4)
        begin
            row_idx = 2'd3;
        end
        else
        begin
            row_idx = 2'(req_row - 3'd1);
        end

        if (req_col == 5'd0)
        begin
            col_clamped = 5'd1;
        end
        else if (req_col > 5'd20)
        begin
            col_clamped = 5'd20;
        end
        else
        begin
            col_clamped = req_col;
        end

        cursor_addr = 8'(row_base(row_idx) + {3'b000, col_clamped} - 8'd1);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // a step emits one event; it waits while the output register is full and stalled
    assign step = (state_reg == ST_RUN) && (!out_valid_reg || m_axis_tready);
    assign cw   = rom_word(upc_reg);

    // datapath driven by the control word
    always_comb
    begin
        case (cw.src)
            SRC_CONST: src_byte = cw.lit;
            SRC_OPND:  src_byte = operand_reg;
            SRC_KEEP:  src_byte = port_reg;
            default:   src_byte = port_reg;
        endcase

        case (cw.part)
            PART_FULL: ev_port = src_byte;
            PART_HI:   ev_port = {src_byte[7:4], 4'h0};
            PART_LO:   ev_port = {src_byte[3:0], 4'h0};
            default:   ev_port = src_byte;
        endcase

        case (cw.hold)
            HOLD_0:    ev_hold = '0;
            HOLD_1:    ev_hold = HoldPulse;
            HOLD_100:  ev_hold = HoldShort;
            HOLD_2000: ev_hold = HoldLong;
            HOLD_GAP:  ev_hold = rs_op_reg ? '0 : HoldShort;
            default:   ev_hold = '0;
        endcase
    end

    // step counter and dispatch
    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    upc_next   = entry_addr(req_op, bus_is_4bit_reg);
                end
            end
            ST_RUN:
            begin
                if (step)
                begin
                    upc_next = upc_reg + UpcW'(1);
                    if (cw.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            upc_reg         <= '0;
            bus_is_4bit_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
            if (cfg_we)
            begin
                bus_is_4bit_reg <= cfg_wdata;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers; every program opens with a fresh byte, so the kept
    // port byte of a pause always comes from the same run
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            operand_reg <= (req_op == OP_CURSOR) ? cursor_addr : req_byte;
            rs_op_reg   <= (req_op == OP_DATA);
        end
        else if (step)
        begin
            port_reg <= ev_port;
            rs_reg   <= cw.rs_from_op && rs_op_reg;
            en_reg   <= cw.en;
            hold_reg <= ev_hold;
            last_reg <= cw.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, hold_reg, en_reg, 1'b0, port_reg};
    assign m_axis_tuser  = rs_reg;
    assign m_axis_tlast  = last_reg;

    // the step counter never leaves the microprogram while a run is live
    a_upc_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (upc_reg < UpcW'(RomDepth)))
        else $error("step counter outside the microprogram");

    // a stalled output freezes the sequencer
    a_stall_holds_upc: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && out_valid_reg && !m_axis_tready) |=> $stable(upc_reg))
        else $error("step counter moved during an output stall");

    // staging the final event of a run frees the request side
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cw.last) |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast))
        else $error("run did not end after its final event");

    // a new run never starts while events of the current run are still pending
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> !s_axis_tready)
        else $error("request taken in the middle of a run");

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for the character lcd write sequencer: random requests, stalls, both bus widths
`timescale 1ns / 1ps

module tb;
    import lcdseq_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PRINT_LIMIT  = 40;
    localparam int PHASE_ITEMS  = 55;

    localparam logic [10:0] PULSE_US  = 11'd1;
    localparam logic [10:0] SETTLE_US = 11'd100;
    localparam logic [10:0] POWER_US  = 11'd2000;

    // lcd command bytes used by the power-up sequence
    localparam logic [7:0] CMD_WAKE_A     = 8'h33;
    localparam logic [7:0] CMD_WAKE_B     = 8'h32;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0E;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

    typedef struct {
        lcd_op_t    op;
        logic [7:0] byte_value;
        logic [4:0] column;
        logic [2:0] row;
    } lcd_req_t;

    typedef struct {
        logic [7:0]  port_byte;
        logic        reg_select;
        logic        read_write;
        logic        enable_pin;
        logic [10:0] hold_us;
        logic        last_event;
    } pin_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;       // byte_value[7:0], column[12:8], row[15:13]
    logic [1:0]  s_axis_tuser = OP_INIT;  // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // port_byte[7:0], read_write[8], enable_pin[9],
                                          // hold_us[20:10], zero fill
    logic        m_axis_tuser;            // reg_select
    logic        m_axis_tlast;            // last_event

    lcd_req_t   requests_pending[$];
    pin_event_t pin_events_due[$];
    pin_event_t run_events[$];

    logic       bus_4bit = 1'b1;
    logic [7:0] held_port;
    lcd_req_t   req_on_bus;
    int         src_gap = 0;
    int         src_calm = 0;
    int         snk_gap = 0;
    int         snk_calm = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    char_lcd_bus_write_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ddram address of column 1 on each row
    function automatic logic [7:0] line_start(input logic [2:0] r);
        logic [7:0] a;
        case (r)
            3'd1:    a = 8'h80;
            3'd2:    a = 8'hC0;
            3'd3:    a = 8'h94;
            default: a = 8'hD4;
        endcase
        return a;
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int idle_span(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic emit_pin(input logic [7:0] port, input logic rs, input logic en,
                            input logic [10:0] hold);
        pin_event_t ev;
        ev.port_byte  = port;
        ev.reg_select = rs;
        ev.read_write = 1'b0;
        ev.enable_pin = en;
        ev.hold_us    = hold;
        ev.last_event = 1'b0;
        run_events.push_back(ev);
        held_port = port;
    endtask

    // pause event: port kept, rs and en low
    task automatic hold_pause(input logic [10:0] hold);
        emit_pin(held_port, 1'b0, 1'b0, hold);
    endtask

    task automatic send_byte(input logic [7:0] v, input logic rs);
        logic [10:0] gap;
        gap = rs ? 11'd0 : SETTLE_US;
        if (bus_4bit)
        begin
            emit_pin({v[7:4], 4'h0}, rs, 1'b1, PULSE_US);
            emit_pin({v[7:4], 4'h0}, rs, 1'b0, gap);
            emit_pin({v[3:0], 4'h0}, rs, 1'b1, PULSE_US);
            emit_pin({v[3:0], 4'h0}, rs, 1'b0, SETTLE_US);
        end
        else
        begin
            emit_pin(v, rs, 1'b1, PULSE_US);
            emit_pin(v, rs, 1'b0, SETTLE_US);
        end
    endtask

    task automatic predict_pin_events(input lcd_req_t req);
        logic [2:0] r;
        logic [4:0] c;
        pin_event_t ev;
        held_port = 8'h00;
        case (req.op)
            OP_INIT:
            begin
                if (bus_4bit)
                begin
                    emit_pin(8'h00, 1'b0, 1'b0, 11'd0);
                    send_byte(CMD_WAKE_A, 1'b0);
                    send_byte(CMD_WAKE_B, 1'b0);
                    send_byte(CMD_FUNC_4BIT, 1'b0);
                end
                else
                begin
                    emit_pin(8'h00, 1'b0, 1'b0, POWER_US);
                    send_byte(CMD_FUNC_8BIT, 1'b0);
                end
                send_byte(CMD_DISPLAY_ON, 1'b0);
                send_byte(CMD_CLEAR, 1'b0);
                hold_pause(POWER_US);
                send_byte(CMD_ENTRY_MODE, 1'b0);
            end
            OP_CMD:
                send_byte(req.byte_value, 1'b0);
            OP_DATA:
                send_byte(req.byte_value, 1'b1);
            OP_CURSOR:
            begin
                // row and column clamped into the display
                r = req.row;
                c = req.column;
                if (r < 3'd1) r = 3'd1;
                if (r > 3'd4) r = 3'd4;
                if (c < 5'd1) c = 5'd1;
                if (c > 5'd20) c = 5'd20;
                send_byte(line_start(r) + {3'b000, c} - 8'd1, 1'b0);
                hold_pause(SETTLE_US);
            end
        endcase
        while (run_events.size() != 0)
        begin
            ev = run_events.pop_front();
            ev.last_event = (run_events.size() == 0);
            pin_events_due.push_back(ev);
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want)
            flag_mismatch(what, got, want);
    endtask

    task automatic check_pin_event();
        pin_event_t want;
        if (pin_events_due.size() == 0)
        begin
            flag_mismatch("pin event with nothing expected", int'(m_axis_tdata), 0);
            return;
        end
        want = pin_events_due.pop_front();
        compare_field("port_byte", int'(m_axis_tdata[7:0]), int'(want.port_byte));
        compare_field("read_write", int'(m_axis_tdata[8]), int'(want.read_write));
        compare_field("enable_pin", int'(m_axis_tdata[9]), int'(want.enable_pin));
        compare_field("hold_us", int'(m_axis_tdata[20:10]), int'(want.hold_us));
        compare_field("tdata zero fill", int'(m_axis_tdata[23:21]), 0);
        compare_field("reg_select", int'(m_axis_tuser), int'(want.reg_select));
        compare_field("last_event", int'(m_axis_tlast), int'(want.last_event));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_INIT;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_pin_events(req_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    src_gap--;
                end
                else if (requests_pending.size() != 0)
                begin
                    req_on_bus = requests_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req_on_bus.row, req_on_bus.column, req_on_bus.byte_value};
                    s_axis_tuser  <= req_on_bus.op;
                    src_gap = idle_span(src_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // pin event monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_pin_event();
            if (snk_gap != 0)
            begin
                m_axis_tready <= 1'b0;
                snk_gap--;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                snk_gap = idle_span(snk_calm);
                m_axis_tready <= (snk_gap == 0);
                if (snk_gap != 0)
                    snk_gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** char_lcd_bus_write_sequencer: FAILED **");
            $finish;
        end
    end

    task automatic add_request(input lcd_op_t op, input logic [7:0] b,
                               input logic [4:0] c, input logic [2:0] r);
        lcd_req_t req;
        req.op         = op;
        req.byte_value = b;
        req.column     = c;
        req.row        = r;
        requests_pending.push_back(req);
    endtask

    task automatic add_random_request();
        lcd_op_t    op;
        logic [4:0] c;
        logic [2:0] r;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            op = OP_INIT;
        else if (pick < 40)
            op = OP_CMD;
        else if (pick < 70)
            op = OP_DATA;
        else
            op = OP_CURSOR;
        // mostly on-screen positions, sometimes anything the fields hold
        c = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 20)) : 5'($urandom_range(0, 31));
        r = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        add_request(op, 8'($urandom), c, r);
    endtask

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (requests_pending.size() != 0 || s_axis_tvalid || pin_events_due.size() != 0);
    endtask

    // bus width changes only once the block has drained
    task automatic set_bus_width(input logic four_bit);
        wait_until_idle();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= four_bit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bus_4bit = four_bit;
    endtask

    initial
    begin
        int ph;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, 4-bit bus from reset
        add_request(OP_INIT, 8'h5C, 5'd31, 3'd7);
        add_request(OP_CMD, 8'h00, 5'd0, 3'd0);
        add_request(OP_CMD, 8'hFF, 5'd31, 3'd7);
        add_request(OP_CMD, 8'h5A, 5'd10, 3'd2);
        add_request(OP_DATA, 8'h00, 5'd31, 3'd7);
        add_request(OP_DATA, 8'hFF, 5'd0, 3'd0);
        add_request(OP_DATA, 8'hC3, 5'd5, 3'd1);
        add_request(OP_CURSOR, 8'h00, 5'd1, 3'd1);
        add_request(OP_CURSOR, 8'hFF, 5'd20, 3'd2);
        add_request(OP_CURSOR, 8'h3C, 5'd7, 3'd3);
        add_request(OP_CURSOR, 8'h00, 5'd20, 3'd4);
        add_request(OP_CURSOR, 8'h00, 5'd0, 3'd0);
        add_request(OP_CURSOR, 8'hFF, 5'd31, 3'd7);
        add_request(OP_CURSOR, 8'hFF, 5'd21, 3'd5);

        // directed, 8-bit bus
        set_bus_width(1'b0);
        add_request(OP_INIT, 8'hFF, 5'd0, 3'd0);
        add_request(OP_CMD, 8'hFF, 5'd16, 3'd4);
        add_request(OP_DATA, 8'h00, 5'd1, 3'd1);
        add_request(OP_DATA, 8'hFF, 5'd20, 3'd4);
        add_request(OP_CURSOR, 8'h00, 5'd1, 3'd1);
        add_request(OP_CURSOR, 8'h00, 5'd20, 3'd4);
        add_request(OP_CURSOR, 8'hAA, 5'd31, 3'd0);
        add_request(OP_CURSOR, 8'h55, 5'd0, 3'd6);

        // random phases, bus width switched between them
        for (ph = 0; ph < 6; ph++)
        begin
            set_bus_width((ph == 4) ? 1'($urandom_range(0, 1)) : 1'((ph + 1) % 2));
            repeat (PHASE_ITEMS) add_random_request();
        end

        wait_until_idle();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && pin_events_due.size() == 0)
            $display("** char_lcd_bus_write_sequencer: PASSED **");
        else
            $display("** char_lcd_bus_write_sequencer: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/lcdseq_pkg.sv
hdl/char_lcd_bus_write_sequencer.sv
bench/tb.sv
